// File: rtl/core/pfse_pkg.sv
package pfse_pkg;

	localparam int NUM_W  = 20;
	localparam int MULT_W = 5;
	localparam int DCNT_W = 8;
	localparam int DIV_STEPS = NUM_W;

	localparam logic FUNC_BUILD  = 1'b0;
	localparam logic FUNC_FACTOR = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;
	localparam logic [1:0] ST_BUILT     = 2'd3;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CLR   = 10'b0000000010,
		S_CHK   = 10'b0000000100,
		S_ITEST = 10'b0000001000,
		S_MRD   = 10'b0000010000,
		S_MWR   = 10'b0000100000,
		S_LOOK  = 10'b0001000000,
		S_LWAIT = 10'b0010000000,
		S_DIV   = 10'b0100000000,
		S_NEXT  = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic [NUM_W-1:0]  prime;
		logic [MULT_W-1:0] mult;
		logic [DCNT_W-1:0] dcnt;
		logic              last;
		logic [1:0]        status;
	} result_t;

	function automatic result_t mk_res(logic [NUM_W-1:0] prime, logic [MULT_W-1:0] mult,
		logic [DCNT_W-1:0] dcnt, logic last, logic [1:0] status);
		result_t r;
		r.prime  = prime;
		r.mult   = mult;
		r.dcnt   = dcnt;
		r.last   = last;
		r.status = status;
		return r;
	endfunction

endpackage

// File: rtl/core/pfse_ram.sv
module pfse_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 524288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/prime_factor_sieve_engine.sv
// Smallest-prime-factor sieve and factorizer.
// Requests: start with func/number, taken at a clock edge where start is high
// and busy is low. Limit register: cfg_we/cfg_wdata, write only while idle.
// func = build: clears the table entries up to the limit (one entry a cycle),
// then sieves odd primes p with p*p <= limit, each table mark a read state
// (S_MRD) and a write state (S_MWR). One result with status 3 follows; the
// build time is set by the single table memory port pair.
// func = factor: one result per distinct prime, ascending, with its exponent;
// the last one carries the divisor count. Each prime step costs a table
// lookup (S_LOOK, plus S_LWAIT for odd cofactors), a step state (S_NEXT)
// and a shift-subtract division (S_DIV), skipped when dividing by two or by
// the cofactor itself.
// Refused requests (no table yet, zero, above the built limit) and the
// number one answer with one result the cycle after the request.
// Results: strobe marks one cycle of prime/multiplicity/divisor_count/last/
// status. The receiver cannot stall; a new request may be taken while the
// final result is shown.
// Reset: no table, limit register 1048575. Table contents stay undefined
// until a build.
module prime_factor_sieve_engine #(
	parameter int MAX_N = 1048576
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [pfse_pkg::NUM_W-1:0]     number,
	input  logic                           cfg_we,
	input  logic [pfse_pkg::NUM_W-1:0]     cfg_wdata,
	output logic                           strobe,
	output logic [pfse_pkg::NUM_W-1:0]     prime,
	output logic [pfse_pkg::MULT_W-1:0]    multiplicity,
	output logic [pfse_pkg::DCNT_W-1:0]    divisor_count,
	output logic                           last,
	output logic [1:0]                     status
);

	localparam int DEPTH = MAX_N / 2;
	localparam int AW = $clog2(DEPTH);
	localparam logic [31:0] CAP = 32'(MAX_N - 1);
	localparam int NW = pfse_pkg::NUM_W;

	pfse_pkg::state_t  state_q;
	pfse_pkg::result_t res_q;
	logic              strobe_q;
	logic [NW-1:0]     max_q;
	logic              built_q;
	logic [NW-1:0]     blim_q;
	logic [NW-1:0]     lim_q;
	logic [NW-1:0]     entries_q;
	logic [NW:0]       m_q;
	logic [9:0]        i_q;
	logic [10:0]       p_q;
	logic [NW:0]       sqi_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     fac_q;
	logic [pfse_pkg::MULT_W-1:0] mult_q;
	logic [pfse_pkg::DCNT_W-1:0] dcnt_q;
	logic              has_q;
	logic [4:0]        dcyc_q;

	logic [NW-1:0]     lim_d;
	logic [NW:0]       ent_sum;
	logic [NW-1:0]     ent_d;
	logic [NW:0]       m_nxt;
	logic              clr_go;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [NW-1:0]     mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [NW-1:0]     mem_rdata;
	logic              take;
	logic [NW-1:0]     t_d;
	logic [NW:0]       rsh;
	logic [NW:0]       diff;
	logic              ge;
	logic [13:0]       dprod_w;
	logic [pfse_pkg::DCNT_W-1:0] dprod;
	logic [NW:0]       sqi_step;

	assign lim_d = ({12'd0, max_q} > CAP) ? CAP[NW-1:0] : max_q;
	assign ent_sum = {1'b0, lim_d} + 21'd1;
	assign ent_d = ent_sum[NW:1];

	assign m_nxt = m_q + 21'(p_q);
	assign clr_go = m_q < {1'b0, entries_q};
	assign sqi_step = 21'({{1'b0, i_q} + 11'd1, 2'b00});

	assign mem_we = ((state_q == pfse_pkg::S_CLR) && clr_go) ||
		((state_q == pfse_pkg::S_MWR) && (mem_rdata == '0));
	assign mem_waddr = AW'(m_q);
	assign mem_wdata = (state_q == pfse_pkg::S_CLR) ? '0 : NW'(p_q);

	always_comb begin
		case (state_q)
			pfse_pkg::S_CHK: mem_raddr = AW'(i_q);
			pfse_pkg::S_MRD: mem_raddr = AW'(m_q);
			default:         mem_raddr = AW'(n_q[NW-1:1]);
		endcase
	end

	pfse_ram #(
		.WIDTH(NW),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// unmarked odd entry means the cofactor itself is prime
	always_comb begin
		if (state_q == pfse_pkg::S_LWAIT) begin
			t_d = (mem_rdata < 20'd2 || mem_rdata > n_q) ? n_q : mem_rdata;
		end else begin
			t_d = 20'd2;
		end
	end
	assign take = ((state_q == pfse_pkg::S_LOOK) && !n_q[0]) ||
		(state_q == pfse_pkg::S_LWAIT);

	assign rsh = {rem_q, n_q[NW-1]};
	assign diff = rsh - {1'b0, fac_q};
	assign ge = rsh >= {1'b0, fac_q};

	assign dprod_w = {6'd0, dcnt_q} * {8'd0, {1'b0, mult_q} + 6'd1};
	assign dprod = dprod_w[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pfse_pkg::S_IDLE;
			res_q     <= '0;
			strobe_q  <= 1'b0;
			max_q     <= 20'hFFFFF;
			built_q   <= 1'b0;
			blim_q    <= '0;
			lim_q     <= '0;
			entries_q <= '0;
			m_q       <= '0;
			i_q       <= '0;
			p_q       <= '0;
			sqi_q     <= '0;
			n_q       <= '0;
			rem_q     <= '0;
			fac_q     <= '0;
			mult_q    <= '0;
			dcnt_q    <= '0;
			has_q     <= 1'b0;
			dcyc_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			case (state_q)
				pfse_pkg::S_IDLE: begin
					if (start) begin
						if (func == pfse_pkg::FUNC_BUILD) begin
							lim_q     <= lim_d;
							entries_q <= ent_d;
							m_q       <= '0;
							state_q   <= pfse_pkg::S_CLR;
						end else if (!built_q) begin
							res_q    <= pfse_pkg::mk_res('0, '0, '0, 1'b1,
								pfse_pkg::ST_NOT_BUILT);
							strobe_q <= 1'b1;
						end else if (number == '0 || number > blim_q) begin
							res_q    <= pfse_pkg::mk_res('0, '0, '0, 1'b1,
								pfse_pkg::ST_RANGE);
							strobe_q <= 1'b1;
						end else if (number == 20'd1) begin
							res_q    <= pfse_pkg::mk_res('0, '0, 8'd1, 1'b1,
								pfse_pkg::ST_OK);
							strobe_q <= 1'b1;
						end else begin
							n_q     <= number;
							has_q   <= 1'b0;
							dcnt_q  <= 8'd1;
							state_q <= pfse_pkg::S_LOOK;
						end
					end
				end
				pfse_pkg::S_CLR: begin
					if (clr_go) begin
						m_q <= m_q + 21'd1;
					end else begin
						i_q     <= 10'd1;
						p_q     <= 11'd3;
						sqi_q   <= 21'd4;
						state_q <= pfse_pkg::S_CHK;
					end
				end
				pfse_pkg::S_CHK: begin
					if ({sqi_q, 1'b1} > {2'b0, lim_q}) begin
						built_q  <= 1'b1;
						blim_q   <= lim_q;
						res_q    <= pfse_pkg::mk_res('0, '0, '0, 1'b1, pfse_pkg::ST_BUILT);
						strobe_q <= 1'b1;
						state_q  <= pfse_pkg::S_IDLE;
					end else begin
						state_q <= pfse_pkg::S_ITEST;
					end
				end
				pfse_pkg::S_ITEST: begin
					if (mem_rdata != '0) begin
						i_q     <= i_q + 10'd1;
						p_q     <= p_q + 11'd2;
						sqi_q   <= sqi_q + sqi_step;
						state_q <= pfse_pkg::S_CHK;
					end else begin
						m_q     <= sqi_q;
						state_q <= pfse_pkg::S_MRD;
					end
				end
				pfse_pkg::S_MRD: begin
					state_q <= pfse_pkg::S_MWR;
				end
				pfse_pkg::S_MWR: begin
					m_q <= m_nxt;
					if (m_nxt < {1'b0, entries_q}) begin
						state_q <= pfse_pkg::S_MRD;
					end else begin
						i_q     <= i_q + 10'd1;
						p_q     <= p_q + 11'd2;
						sqi_q   <= sqi_q + sqi_step;
						state_q <= pfse_pkg::S_CHK;
					end
				end
				pfse_pkg::S_LOOK: begin
					state_q <= pfse_pkg::S_LWAIT;
				end
				pfse_pkg::S_LWAIT: begin
					state_q <= pfse_pkg::S_NEXT;
				end
				pfse_pkg::S_DIV: begin
					rem_q  <= ge ? diff[NW-1:0] : rsh[NW-1:0];
					n_q    <= {n_q[NW-2:0], ge};
					dcyc_q <= dcyc_q - 5'd1;
					if (dcyc_q == '0) begin
						state_q <= pfse_pkg::S_NEXT;
					end
				end
				pfse_pkg::S_NEXT: begin
					if (n_q == 20'd1) begin
						res_q    <= pfse_pkg::mk_res(fac_q, mult_q, dprod, 1'b1,
							pfse_pkg::ST_OK);
						strobe_q <= 1'b1;
						state_q  <= pfse_pkg::S_IDLE;
					end else begin
						state_q <= pfse_pkg::S_LOOK;
					end
				end
				default: begin
					state_q <= pfse_pkg::S_IDLE;
				end
			endcase

			if (take) begin
				if (has_q && fac_q == t_d) begin
					mult_q <= mult_q + 5'd1;
				end else begin
					if (has_q) begin
						res_q    <= pfse_pkg::mk_res(fac_q, mult_q, '0, 1'b0, pfse_pkg::ST_OK);
						strobe_q <= 1'b1;
						dcnt_q   <= dprod;
					end
					fac_q  <= t_d;
					mult_q <= 5'd1;
					has_q  <= 1'b1;
				end
				if (t_d == 20'd2) begin
					n_q     <= {1'b0, n_q[NW-1:1]};
					state_q <= pfse_pkg::S_NEXT;
				end else if (t_d == n_q) begin
					n_q     <= 20'd1;
					state_q <= pfse_pkg::S_NEXT;
				end else begin
					rem_q   <= '0;
					dcyc_q  <= 5'(pfse_pkg::DIV_STEPS - 1);
					state_q <= pfse_pkg::S_DIV;
				end
			end
		end
	end

	assign busy          = state_q != pfse_pkg::S_IDLE;
	assign strobe        = strobe_q;
	assign prime         = res_q.prime;
	assign multiplicity  = res_q.mult;
	assign divisor_count = res_q.dcnt;
	assign last          = res_q.last;
	assign status        = res_q.status;

endmodule
